@@ src/insph_pkg.sv @@
`default_nettype none
package insph_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int SLOT_BITS = 16;
  localparam int PT_BITS = 3 * SLOT_BITS;
  localparam int LANES = 4;
endpackage
`default_nettype wire

@@ src/insph_lane.sv @@
`default_nettype none
// One cofactor lane: forms the 3x3 minor of three difference rows, then
// multiplies it by the squared length of the excluded row, sign applied.
// Seven register stages; rows arrive already differenced (stage 0 outside).
// The wide product is split into four narrow partial products.
module insph_lane #(
  parameter int DB = 17,
  parameter int TB = 5 * DB + 5
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic                  neg_sign,
  input  wire logic signed [DB-1:0]  r0 [3],
  input  wire logic signed [DB-1:0]  r1 [3],
  input  wire logic signed [DB-1:0]  r2 [3],
  input  wire logic signed [DB-1:0]  dl [3],
  output logic signed [TB-1:0]       term
);
  localparam int PB = 2 * DB;
  localparam int MB = 3 * DB + 3;
  localparam int LB = 2 * DB + 2;
  localparam int MLO = MB / 2;
  localparam int MHI = MB - MLO;
  localparam int LLO = LB / 2;
  localparam int LHI = LB - LLO;
  localparam int PW = MHI + LHI;
  // stage 1: 2x2 minors and squared length pieces
  logic signed [PB:0]   c0_r, c1_r, c2_r;
  logic signed [DB-1:0] a0_r, a1_r, a2_r;
  logic [LB-1:0]        len1_r;
  // stage 2: three products
  logic signed [MB-1:0] t0_r, t1_r, t2_r;
  logic [LB-1:0]        len2_r;
  // stage 3: minor
  logic signed [MB-1:0] m_r;
  logic [LB-1:0]        len3_r;
  logic                 s1_r, s2_r, s3_r;
  // stage 4: magnitude of the minor, sign folded in
  logic [MB-1:0]        mag_r;
  logic [LB-1:0]        len4_r;
  logic                 s4_r;
  // stage 5: partial products
  logic [PW-1:0]        p00_r, p01_r, p10_r, p11_r;
  logic                 s5_r;
  // stage 6: unsigned product
  logic [TB-1:0]        u_r;
  logic                 s6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c0_r <= (PB+1)'(r1[1] * r2[2]) - (PB+1)'(r1[2] * r2[1]);
      c1_r <= (PB+1)'(r1[0] * r2[2]) - (PB+1)'(r1[2] * r2[0]);
      c2_r <= (PB+1)'(r1[0] * r2[1]) - (PB+1)'(r1[1] * r2[0]);
      a0_r <= r0[0];
      a1_r <= r0[1];
      a2_r <= r0[2];
      len1_r <= LB'(unsigned'(PB'(dl[0] * dl[0]))) + LB'(unsigned'(PB'(dl[1] * dl[1])))
              + LB'(unsigned'(PB'(dl[2] * dl[2])));
      s1_r <= neg_sign;
      t0_r <= MB'(a0_r * c0_r);
      t1_r <= MB'(a1_r * c1_r);
      t2_r <= MB'(a2_r * c2_r);
      len2_r <= len1_r;
      s2_r <= s1_r;
      m_r <= t0_r - t1_r + t2_r;
      len3_r <= len2_r;
      s3_r <= s2_r;
      mag_r <= m_r[MB-1] ? unsigned'(-m_r) : unsigned'(m_r);
      len4_r <= len3_r;
      s4_r <= s3_r ^ m_r[MB-1];
      p00_r <= PW'(mag_r[MLO-1:0]) * PW'(len4_r[LLO-1:0]);
      p01_r <= PW'(mag_r[MLO-1:0]) * PW'(len4_r[LB-1:LLO]);
      p10_r <= PW'(mag_r[MB-1:MLO]) * PW'(len4_r[LLO-1:0]);
      p11_r <= PW'(mag_r[MB-1:MLO]) * PW'(len4_r[LB-1:LLO]);
      s5_r <= s4_r;
      u_r <= TB'(p00_r) + (TB'(p01_r) << LLO) + (TB'(p10_r) << MLO)
           + (TB'(p11_r) << (MLO + LLO));
      s6_r <= s5_r;
      term <= s6_r ? -signed'(u_r) : signed'(u_r);
    end
  end
endmodule
`default_nettype wire

@@ src/insph_merge.sv @@
`default_nettype none
// Sum the four signed cofactor terms over two stages and test for > 0.
module insph_merge #(
  parameter int TB = 77
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic signed [TB-1:0] t [insph_pkg::LANES],
  output logic                     pos
);
  logic signed [TB+1:0] s0_r, s1_r;
  logic signed [TB+1:0] sum;
  always_comb sum = s0_r + s1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= (TB+2)'(t[0]) + (TB+2)'(t[1]);
      s1_r <= (TB+2)'(t[2]) + (TB+2)'(t[3]);
      pos  <= !sum[TB+1] && (sum != '0);
    end
  end
endmodule
`default_nettype wire

@@ src/insphere_predicate.sv @@
`default_nettype none
// Exact lifted in-sphere determinant sign, one item per cycle.
// Pipeline: a difference stage, seven lane stages of the cofactor multipliers,
// then two adder stages with output.
// Throughput: one item per cycle; the pipeline stalls only when out_ready low.
// Reset: synchronous active-low rst_n clears valid bits; data is not reset.
module insphere_predicate #(
  parameter int COORD_BITS = insph_pkg::COORD_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [insph_pkg::PT_BITS-1:0] in_query_point,
  input  wire logic [insph_pkg::PT_BITS-1:0] in_vertex_a,
  input  wire logic [insph_pkg::PT_BITS-1:0] in_vertex_b,
  input  wire logic [insph_pkg::PT_BITS-1:0] in_vertex_c,
  input  wire logic [insph_pkg::PT_BITS-1:0] in_vertex_d,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_det_positive
);
  localparam int DB = COORD_BITS + 1;
  localparam int TB = 5 * DB + 5;
  localparam int DEPTH = 10;

  logic [DEPTH-1:0] v_r;
  logic en;
  // whole pipeline advances unless the output holds an untaken item
  assign en = !(v_r[DEPTH-1] && !out_ready);
  assign in_ready = en;
  assign out_valid = v_r[DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[DEPTH-2:0], in_valid};
    end
  end

  logic [insph_pkg::PT_BITS-1:0] vin [4];
  assign vin[0] = in_vertex_a;
  assign vin[1] = in_vertex_b;
  assign vin[2] = in_vertex_c;
  assign vin[3] = in_vertex_d;

  logic signed [DB-1:0] d_r [4][3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int k = 0; k < 3; k++) begin
          d_r[i][k] <= DB'(signed'(vin[i][k*insph_pkg::SLOT_BITS +: COORD_BITS]))
                     - DB'(signed'(in_query_point[k*insph_pkg::SLOT_BITS +: COORD_BITS]));
        end
      end
    end
  end

  logic signed [TB-1:0] term [insph_pkg::LANES];
  // lane i drops row i; odd lanes flip sign (cofactor expansion)
  insph_lane #(.DB(DB), .TB(TB)) u_l0 (.clk, .en, .neg_sign(1'b0),
    .r0(d_r[1]), .r1(d_r[2]), .r2(d_r[3]), .dl(d_r[0]), .term(term[0]));
  insph_lane #(.DB(DB), .TB(TB)) u_l1 (.clk, .en, .neg_sign(1'b1),
    .r0(d_r[0]), .r1(d_r[2]), .r2(d_r[3]), .dl(d_r[1]), .term(term[1]));
  insph_lane #(.DB(DB), .TB(TB)) u_l2 (.clk, .en, .neg_sign(1'b0),
    .r0(d_r[0]), .r1(d_r[1]), .r2(d_r[3]), .dl(d_r[2]), .term(term[2]));
  insph_lane #(.DB(DB), .TB(TB)) u_l3 (.clk, .en, .neg_sign(1'b1),
    .r0(d_r[0]), .r1(d_r[1]), .r2(d_r[2]), .dl(d_r[3]), .term(term[3]));

  insph_merge #(.TB(TB)) u_merge (.clk, .en, .t(term), .pos(out_det_positive));
endmodule
`default_nettype wire
